@@ hdl/wfc_pkg.sv @@
// shared types, constants and the cordic arctangent table for the waypoint follower
`timescale 1ns / 1ps

package wfc_pkg;

    localparam int NUM_WAYPOINTS_DEF = 3;
    localparam int CORDIC_STEPS_DEF  = 16;
    localparam int CORDIC_MAX_STEPS  = 24;
    localparam int STEP_W            = $clog2(CORDIC_MAX_STEPS);

    localparam int DATA_W = 64;
    localparam int ADDR_W = 6;

    localparam int D_W    = 17;   // waypoint minus pose
    localparam int SQ_W   = 34;   // squared distance
    localparam int XY_W   = 28;   // cordic x and y, dx scaled by 256 plus gain
    localparam int Z_W    = 21;   // cordic angle, 2^-16 rad
    localparam int BRG_W  = 18;   // bearing, Q3.13
    localparam int ERR_W  = 19;   // heading error
    localparam int ATAN_W = 17;

    localparam logic signed [Z_W-1:0] PI_Q16 = Z_W'(205887);

    typedef enum logic [1:0] {
        REQ_RANGE = 2'd0,
        REQ_ODOM  = 2'd1,
        REQ_TICK  = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        REG_WP_A      = 3'd0,
        REG_WP_B      = 3'd1,
        REG_WP_C      = 3'd2,
        REG_REACH_SQ  = 3'd3,
        REG_ANGLE_THR = 3'd4,
        REG_TURN_RATE = 3'd5,
        REG_FWD_SPEED = 3'd6,
        REG_OBST_DIST = 3'd7
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SQX,
        ST_SQY,
        ST_CMP,
        ST_ROT,
        ST_RND,
        ST_DEC,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [31:0]     waypoint_a;
        logic [31:0]     waypoint_b;
        logic [31:0]     waypoint_c;
        logic [SQ_W-1:0] reach_dist_sq;
        logic [14:0]     angle_threshold;
        logic [14:0]     turn_rate;
        logic [15:0]     cruise_speed;
        logic [15:0]     obstacle_dist;
    } cfg_t;

    typedef struct packed {
        logic              range_upd;
        logic              odom_upd;
        logic              tick_start;
        logic              sq_x;
        logic              sq_y;
        logic              cmp;
        logic              rot;
        logic              rnd;
        logic              dec;
        logic              emit;
        logic [STEP_W-1:0] step;
    } cmd_t;

    typedef struct packed {
        logic motion_ok;
        logic near;
        logic zero_vec;
        logic out_free;
    } sts_t;

    function automatic logic [ATAN_W-1:0] atan_q16(input logic [STEP_W-1:0] i);
        logic [ATAN_W-1:0] v;
        case (i)
            5'd0:    v = 17'd51472;
            5'd1:    v = 17'd30386;
            5'd2:    v = 17'd16055;
            5'd3:    v = 17'd8150;
            5'd4:    v = 17'd4091;
            5'd5:    v = 17'd2047;
            5'd6:    v = 17'd1024;
            5'd7:    v = 17'd512;
            5'd8:    v = 17'd256;
            5'd9:    v = 17'd128;
            5'd10:   v = 17'd64;
            5'd11:   v = 17'd32;
            5'd12:   v = 17'd16;
            5'd13:   v = 17'd8;
            5'd14:   v = 17'd4;
            5'd15:   v = 17'd2;
            5'd16:   v = 17'd1;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/wfc_ctrl.sv @@
// controller state machine sequencing one item at a time through the datapath
`timescale 1ns / 1ps

module wfc_ctrl #(
    parameter int CORDIC_STEPS = wfc_pkg::CORDIC_STEPS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        req_type,
    input  wfc_pkg::sts_t     sts,
    output wfc_pkg::cmd_t     cmd
);

    localparam int CNT_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_STEPS - 1);

    wfc_pkg::state_t state_reg;
    wfc_pkg::state_t state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             in_acc;

    assign in_acc = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wfc_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            wfc_pkg::ST_IDLE:
            begin
                if (in_acc && req_type == wfc_pkg::REQ_TICK)
                begin
                    state_next = sts.motion_ok ? wfc_pkg::ST_SQX : wfc_pkg::ST_EMIT;
                end
            end
            wfc_pkg::ST_SQX: state_next = wfc_pkg::ST_SQY;
            wfc_pkg::ST_SQY: state_next = wfc_pkg::ST_CMP;
            wfc_pkg::ST_CMP:
            begin
                cnt_next = '0;
                if (sts.near)
                begin
                    state_next = wfc_pkg::ST_EMIT;
                end
                else if (sts.zero_vec)
                begin
                    state_next = wfc_pkg::ST_RND;
                end
                else
                begin
                    state_next = wfc_pkg::ST_ROT;
                end
            end
            wfc_pkg::ST_ROT:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = wfc_pkg::ST_RND;
                end
            end
            wfc_pkg::ST_RND: state_next = wfc_pkg::ST_DEC;
            wfc_pkg::ST_DEC: state_next = wfc_pkg::ST_EMIT;
            wfc_pkg::ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = wfc_pkg::ST_IDLE;
                end
            end
            default: state_next = wfc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready       = (state_reg == wfc_pkg::ST_IDLE);
        cmd            = '0;
        cmd.range_upd  = in_acc && (req_type == wfc_pkg::REQ_RANGE);
        cmd.odom_upd   = in_acc && (req_type == wfc_pkg::REQ_ODOM);
        cmd.tick_start = in_acc && (req_type == wfc_pkg::REQ_TICK);
        cmd.sq_x       = (state_reg == wfc_pkg::ST_SQX);
        cmd.sq_y       = (state_reg == wfc_pkg::ST_SQY);
        cmd.cmp        = (state_reg == wfc_pkg::ST_CMP);
        cmd.rot        = (state_reg == wfc_pkg::ST_ROT);
        cmd.rnd        = (state_reg == wfc_pkg::ST_RND);
        cmd.dec        = (state_reg == wfc_pkg::ST_DEC);
        cmd.emit       = (state_reg == wfc_pkg::ST_EMIT) && sts.out_free;
        cmd.step       = {{(wfc_pkg::STEP_W - CNT_W){1'b0}}, cnt_reg};
    end

endmodule

@@ hdl/wfc_dp.sv @@
// datapath: pose and safety state, squared distance, cordic bearing and output register
`timescale 1ns / 1ps

module wfc_dp #(
    parameter int NUM_WAYPOINTS = wfc_pkg::NUM_WAYPOINTS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  wfc_pkg::cfg_t       cfg,
    input  wfc_pkg::cmd_t       cmd,
    output wfc_pkg::sts_t       sts,
    input  logic [15:0]         range_mm,
    input  logic                scan_last,
    input  logic signed [15:0]  pos_x,
    input  logic signed [15:0]  pos_y,
    input  logic signed [15:0]  yaw,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [15:0]         linear_speed,
    output logic signed [15:0]  angular_rate,
    output logic                reached,
    output logic [1:0]          waypoint_index
);

    localparam int D_W   = wfc_pkg::D_W;
    localparam int SQ_W  = wfc_pkg::SQ_W;
    localparam int XY_W  = wfc_pkg::XY_W;
    localparam int Z_W   = wfc_pkg::Z_W;
    localparam int BRG_W = wfc_pkg::BRG_W;
    localparam int ERR_W = wfc_pkg::ERR_W;
    localparam logic [2:0] NUM_WP = 3'(NUM_WAYPOINTS);

    // sensor and pose state
    logic signed [15:0] pose_x_reg;
    logic signed [15:0] pose_y_reg;
    logic signed [15:0] pose_yaw_reg;
    logic               pose_ok_reg;
    logic               safe_reg;
    logic               scan_close_reg;
    logic [1:0]         target_reg;

    // per-tick working registers
    logic signed [D_W-1:0]   dx_reg;
    logic signed [D_W-1:0]   dy_reg;
    logic [SQ_W-1:0]         sqx_reg;
    logic [SQ_W-1:0]         sqy_reg;
    logic signed [XY_W-1:0]  x_reg;
    logic signed [XY_W-1:0]  y_reg;
    logic signed [Z_W-1:0]   z_reg;
    logic signed [ERR_W-1:0] err_reg;
    logic [15:0]             res_lin_reg;
    logic signed [15:0]      res_ang_reg;
    logic                    res_reached_reg;
    logic [1:0]              res_idx_reg;

    logic                    out_valid_reg;
    logic [15:0]             out_lin_reg;
    logic signed [15:0]      out_ang_reg;
    logic                    out_reached_reg;
    logic [1:0]              out_idx_reg;

    logic [31:0]             wp_sel;
    logic signed [D_W-1:0]   dx_new;
    logic signed [D_W-1:0]   dy_new;
    logic                    close;
    logic                    saw;
    logic                    safe_next;
    logic                    scan_close_next;
    logic [2:0]              target_inc;
    logic [1:0]              target_next;
    logic signed [XY_W-1:0]  x_init;
    logic signed [XY_W-1:0]  y_init;
    logic signed [XY_W-1:0]  y_shift;
    logic signed [XY_W-1:0]  x_shift;
    logic signed [Z_W-1:0]   atan_ext;
    logic [Z_W-1:0]          z_abs;
    logic [Z_W-1:0]          z_rnd;
    logic signed [BRG_W-1:0] brg_mag;
    logic signed [BRG_W-1:0] bearing;
    logic signed [ERR_W-1:0] err_abs;
    logic signed [15:0]      turn_pos;

    always_comb
    begin
        case (target_reg)
            2'd0:    wp_sel = cfg.waypoint_a;
            2'd1:    wp_sel = cfg.waypoint_b;
            default: wp_sel = cfg.waypoint_c;
        endcase
        dx_new = D_W'($signed(wp_sel[31:16])) - D_W'(pose_x_reg);
        dy_new = D_W'($signed(wp_sel[15:0])) - D_W'(pose_y_reg);

        close           = (range_mm < cfg.obstacle_dist);
        saw             = scan_close_reg || close;
        safe_next       = close ? 1'b0 : safe_reg;
        scan_close_next = saw;
        if (scan_last)
        begin
            if (!saw)
            begin
                safe_next = 1'b1;
            end
            scan_close_next = 1'b0;
        end

        target_inc  = {1'b0, target_reg} + 3'd1;
        target_next = (target_inc >= NUM_WP) ? 2'd0 : target_inc[1:0];

        // a vector in the left half plane is turned by pi first
        x_init = {{(XY_W - D_W - 8){dx_reg[D_W-1]}}, dx_reg, 8'd0};
        y_init = {{(XY_W - D_W - 8){dy_reg[D_W-1]}}, dy_reg, 8'd0};

        y_shift  = y_reg >>> cmd.step;
        x_shift  = x_reg >>> cmd.step;
        atan_ext = Z_W'(wfc_pkg::atan_q16(cmd.step));

        // round half away from zero into Q3.13
        z_abs   = z_reg[Z_W-1] ? Z_W'(-z_reg) : Z_W'(z_reg);
        z_rnd   = (z_abs + Z_W'(4)) >> 3;
        brg_mag = BRG_W'(z_rnd);
        bearing = z_reg[Z_W-1] ? -brg_mag : brg_mag;

        err_abs  = err_reg[ERR_W-1] ? -err_reg : err_reg;
        turn_pos = $signed({1'b0, cfg.turn_rate});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_yaw_reg   <= '0;
            pose_ok_reg    <= 1'b0;
            safe_reg       <= 1'b1;
            scan_close_reg <= 1'b0;
            target_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.range_upd)
            begin
                safe_reg       <= safe_next;
                scan_close_reg <= scan_close_next;
            end
            if (cmd.odom_upd)
            begin
                pose_x_reg   <= pos_x;
                pose_y_reg   <= pos_y;
                pose_yaw_reg <= yaw;
                pose_ok_reg  <= 1'b1;
            end
            if (cmd.cmp && sts.near)
            begin
                target_reg <= target_next;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.tick_start)
        begin
            dx_reg          <= dx_new;
            dy_reg          <= dy_new;
            res_lin_reg     <= '0;
            res_ang_reg     <= '0;
            res_reached_reg <= 1'b0;
            res_idx_reg     <= target_reg;
        end
        if (cmd.sq_x)
        begin
            sqx_reg <= SQ_W'(dx_reg * dx_reg);
        end
        if (cmd.sq_y)
        begin
            sqy_reg <= SQ_W'(dy_reg * dy_reg);
        end
        if (cmd.cmp)
        begin
            if (sts.near)
            begin
                res_reached_reg <= 1'b1;
            end
            if (dx_reg[D_W-1])
            begin
                x_reg <= -x_init;
                y_reg <= -y_init;
                z_reg <= dy_reg[D_W-1] ? -wfc_pkg::PI_Q16 : wfc_pkg::PI_Q16;
            end
            else
            begin
                x_reg <= x_init;
                y_reg <= y_init;
                z_reg <= '0;
            end
        end
        if (cmd.rot)
        begin
            if (y_reg[XY_W-1])
            begin
                x_reg <= x_reg - y_shift;
                y_reg <= y_reg + x_shift;
                z_reg <= z_reg - atan_ext;
            end
            else
            begin
                x_reg <= x_reg + y_shift;
                y_reg <= y_reg - x_shift;
                z_reg <= z_reg + atan_ext;
            end
        end
        if (cmd.rnd)
        begin
            err_reg <= ERR_W'(bearing) - ERR_W'(pose_yaw_reg);
        end
        if (cmd.dec)
        begin
            if (err_abs > $signed({4'd0, cfg.angle_threshold}))
            begin
                res_ang_reg <= (err_reg > 0) ? turn_pos : -turn_pos;
            end
            else
            begin
                res_lin_reg <= cfg.cruise_speed;
            end
        end
        if (cmd.emit)
        begin
            out_lin_reg     <= res_lin_reg;
            out_ang_reg     <= res_ang_reg;
            out_reached_reg <= res_reached_reg;
            out_idx_reg     <= res_idx_reg;
        end
    end

    always_comb
    begin
        sts.motion_ok = safe_reg && pose_ok_reg;
        sts.near      = ((sqx_reg + sqy_reg) < cfg.reach_dist_sq);
        sts.zero_vec  = (dx_reg == '0) && (dy_reg == '0);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign linear_speed   = out_lin_reg;
    assign angular_rate   = out_ang_reg;
    assign reached        = out_reached_reg;
    assign waypoint_index = out_idx_reg;

endmodule

@@ hdl/waypoint_follow_controller.sv @@
// top level: register file on the apb port, controller and datapath
// an odometry pose or range sample item is handled in the idle state and the next item is taken right after
// a tick item goes from idle straight to emit when motion is blocked, through sqx, sqy and cmp to emit
// when the waypoint is reached, adds rnd and dec with a zero offset, else also the cordic rot loop
// the result sits in an output register, so the next item is taken while it waits
// reset clears pose, waypoint index and output valid, sets the safety flag, and loads register defaults
`timescale 1ns / 1ps

module waypoint_follow_controller #(
    parameter int NUM_WAYPOINTS = wfc_pkg::NUM_WAYPOINTS_DEF,
    parameter int CORDIC_STEPS  = wfc_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [wfc_pkg::ADDR_W-1:0]    paddr,
    input  logic [wfc_pkg::DATA_W-1:0]    pwdata,
    output logic [wfc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    req_type,
    input  logic [15:0]                   range_mm,
    input  logic                          scan_last,
    input  logic signed [15:0]            pos_x,
    input  logic signed [15:0]            pos_y,
    input  logic signed [15:0]            yaw,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [15:0]                   linear_speed,
    output logic signed [15:0]            angular_rate,
    output logic                          reached,
    output logic [1:0]                    waypoint_index
);

    localparam int DATA_W = wfc_pkg::DATA_W;

    wfc_pkg::cfg_t     cfg_reg;
    wfc_pkg::cmd_t     cmd;
    wfc_pkg::sts_t     sts;
    wfc_pkg::reg_idx_t reg_sel;
    logic              wr_en;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_sel = wfc_pkg::reg_idx_t'(paddr[5:3]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.waypoint_a      <= '0;
            cfg_reg.waypoint_b      <= '0;
            cfg_reg.waypoint_c      <= '0;
            cfg_reg.reach_dist_sq   <= 34'd90000;
            cfg_reg.angle_threshold <= 15'd819;
            cfg_reg.turn_rate       <= 15'd1638;
            cfg_reg.cruise_speed    <= 16'd500;
            cfg_reg.obstacle_dist   <= 16'd500;
        end
        else if (wr_en)
        begin
            case (reg_sel)
                wfc_pkg::REG_WP_A:      cfg_reg.waypoint_a      <= pwdata[31:0];
                wfc_pkg::REG_WP_B:      cfg_reg.waypoint_b      <= pwdata[31:0];
                wfc_pkg::REG_WP_C:      cfg_reg.waypoint_c      <= pwdata[31:0];
                wfc_pkg::REG_REACH_SQ:  cfg_reg.reach_dist_sq   <= pwdata[33:0];
                wfc_pkg::REG_ANGLE_THR: cfg_reg.angle_threshold <= pwdata[14:0];
                wfc_pkg::REG_TURN_RATE: cfg_reg.turn_rate       <= pwdata[14:0];
                wfc_pkg::REG_FWD_SPEED: cfg_reg.cruise_speed    <= pwdata[15:0];
                wfc_pkg::REG_OBST_DIST: cfg_reg.obstacle_dist   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            wfc_pkg::REG_WP_A:      prdata = DATA_W'(cfg_reg.waypoint_a);
            wfc_pkg::REG_WP_B:      prdata = DATA_W'(cfg_reg.waypoint_b);
            wfc_pkg::REG_WP_C:      prdata = DATA_W'(cfg_reg.waypoint_c);
            wfc_pkg::REG_REACH_SQ:  prdata = DATA_W'(cfg_reg.reach_dist_sq);
            wfc_pkg::REG_ANGLE_THR: prdata = DATA_W'(cfg_reg.angle_threshold);
            wfc_pkg::REG_TURN_RATE: prdata = DATA_W'(cfg_reg.turn_rate);
            wfc_pkg::REG_FWD_SPEED: prdata = DATA_W'(cfg_reg.cruise_speed);
            wfc_pkg::REG_OBST_DIST: prdata = DATA_W'(cfg_reg.obstacle_dist);
            default:                prdata = '0;
        endcase
    end

    wfc_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .sts      (sts),
        .cmd      (cmd)
    );

    wfc_dp #(
        .NUM_WAYPOINTS (NUM_WAYPOINTS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .cmd            (cmd),
        .sts            (sts),
        .range_mm       (range_mm),
        .scan_last      (scan_last),
        .pos_x          (pos_x),
        .pos_y          (pos_y),
        .yaw            (yaw),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .linear_speed   (linear_speed),
        .angular_rate   (angular_rate),
        .reached        (reached),
        .waypoint_index (waypoint_index)
    );

endmodule
